// File: src/spiral_ring_fade_level_assert.svh
// Assertion macros shared by the spiral ring fade level design.
`ifndef SPIRAL_RING_FADE_LEVEL_ASSERT_SVH
`define SPIRAL_RING_FADE_LEVEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/srfl_pkg.sv
// Shared constants and stage types of the spiral ring fade level pipeline.
package srfl_pkg;

  // Cell coordinate and grid size width.
  localparam int COORD_BITS    = 12;
  // Fraction bits of the progress register.
  localparam int FRACTION_BITS = 16;
  localparam int PROG_BITS     = FRACTION_BITS + 1;
  // Category numbers, counts and ring offsets.
  localparam int CNT_BITS      = 2 * COORD_BITS + 1;
  // Category within one ring.
  localparam int CAT_BITS      = COORD_BITS + 1;
  // Output level.
  localparam int LEVEL_BITS    = 8;
  localparam int LEVEL_MAX     = 255;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (PROG_BITS > COORD_BITS) ? PROG_BITS : COORD_BITS;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS   = ((LEVEL_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_PROGRESS    = 2'd2
  } cfg_idx_t;

  // Ring geometry and raw products after the second stage.
  typedef struct packed {
    logic                      outside;
    logic [COORD_BITS-1:0]     r;
    logic [COORD_BITS-1:0]     last;
    logic [COORD_BITS-1:0]     rw;
    logic [COORD_BITS-1:0]     rh;
    logic [COORD_BITS-1:0]     cx;
    logic [COORD_BITS-1:0]     cy;
    logic [COORD_BITS-1:0]     rwl;
    logic [COORD_BITS-1:0]     rhl;
    logic [CNT_BITS-1:0]       pr_sum;
    logic [2*COORD_BITS-1:0]   pr_sq;
    logic [CNT_BITS-1:0]       pl_sum;
    logic [2*COORD_BITS-1:0]   pl_sq;
    logic [PROG_BITS-1:0]      progress;
  } geo_t;

  // Absolute category and category total after the fourth stage.
  typedef struct packed {
    logic                      outside;
    logic [CNT_BITS-1:0]       k;
    logic [CNT_BITS-1:0]       total;
    logic [PROG_BITS-1:0]      progress;
  } cnt_t;

endpackage

// File: src/srfl_geom.sv
// Ring index, ring extents and ring offset products (stages one and two).
module srfl_geom (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ce,
  input  logic                                in_valid,
  input  logic [srfl_pkg::COORD_BITS-1:0]     x,
  input  logic [srfl_pkg::COORD_BITS-1:0]     y,
  input  logic [srfl_pkg::COORD_BITS-1:0]     w,
  input  logic [srfl_pkg::COORD_BITS-1:0]     h,
  input  logic [srfl_pkg::PROG_BITS-1:0]      progress,
  output logic                                out_valid,
  output srfl_pkg::geo_t                      geo
);

  localparam int CB = srfl_pkg::COORD_BITS;

  typedef struct packed {
    logic                  outside;
    logic [CB-1:0]         x;
    logic [CB-1:0]         y;
    logic [CB-1:0]         w;
    logic [CB-1:0]         h;
    logic [CB-1:0]         r;
    logic [CB-1:0]         last;
    logic [CB:0]           sum;
    logic [srfl_pkg::PROG_BITS-1:0] progress;
  } s1_t;

  logic          v1;
  s1_t           s1;
  s1_t           s1_next;
  logic [CB-1:0] dx_r;
  logic [CB-1:0] dy_r;
  logic [CB-1:0] mx;
  logic [CB-1:0] my;
  logic [CB-1:0] m;
  srfl_pkg::geo_t geo_next;

  // Stage one: distance to the nearest border and the innermost ring.
  always_comb begin
    dx_r = w - x - CB'(1);
    dy_r = h - y - CB'(1);
    mx   = (x < dx_r) ? x : dx_r;
    my   = (y < dy_r) ? y : dy_r;
    m    = (w < h) ? w : h;
    s1_next.outside  = (x >= w) || (y >= h);
    s1_next.x        = x;
    s1_next.y        = y;
    s1_next.w        = w;
    s1_next.h        = h;
    s1_next.r        = (mx < my) ? mx : my;
    s1_next.last     = (m - CB'(1)) >> 1;
    s1_next.sum      = {1'b0, w} + {1'b0, h} - (CB+1)'(2);
    s1_next.progress = progress;
  end

  // Stage two: ring extents, coordinates on the ring and ring offset products.
  always_comb begin
    geo_next.outside  = s1.outside;
    geo_next.r        = s1.r;
    geo_next.last     = s1.last;
    geo_next.rw       = s1.w - {s1.r[CB-2:0], 1'b0};
    geo_next.rh       = s1.h - {s1.r[CB-2:0], 1'b0};
    geo_next.cx       = s1.x - s1.r;
    geo_next.cy       = s1.y - s1.r;
    geo_next.rwl      = s1.w - {s1.last[CB-2:0], 1'b0};
    geo_next.rhl      = s1.h - {s1.last[CB-2:0], 1'b0};
    geo_next.pr_sum   = srfl_pkg::CNT_BITS'(s1.r) * srfl_pkg::CNT_BITS'(s1.sum);
    geo_next.pr_sq    = (2*CB)'(s1.r) * (2*CB)'(s1.r);
    geo_next.pl_sum   = srfl_pkg::CNT_BITS'(s1.last) * srfl_pkg::CNT_BITS'(s1.sum);
    geo_next.pl_sq    = (2*CB)'(s1.last) * (2*CB)'(s1.last);
    geo_next.progress = s1.progress;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ce) begin
      s1  <= s1_next;
      geo <= geo_next;
    end
  end

endmodule

// File: src/srfl_count.sv
// Category on the ring, ring offsets and category total (stages three and four).
module srfl_count (
  input  logic            clk,
  input  logic            rst,
  input  logic            ce,
  input  logic            in_valid,
  input  srfl_pkg::geo_t  geo,
  output logic            out_valid,
  output srfl_pkg::cnt_t  cnt
);

  localparam int CB = srfl_pkg::COORD_BITS;
  localparam int CW = srfl_pkg::CAT_BITS;
  localparam int KW = srfl_pkg::CNT_BITS;

  typedef struct packed {
    logic                  outside;
    logic [KW-1:0]         rb_r;
    logic [KW-1:0]         rb_l;
    logic [CW-1:0]         cat;
    logic [CW-1:0]         cnt_l;
    logic [srfl_pkg::PROG_BITS-1:0] progress;
  } s3_t;

  logic          v3;
  s3_t           s3;
  s3_t           s3_next;
  logic [CW-1:0] rw;
  logic [CW-1:0] rh;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-1:0] rwl;
  logic [CW-1:0] rhl;
  srfl_pkg::cnt_t cnt_next;

  // Stage three: position on the ring and offsets of the rings before it.
  always_comb begin
    rw  = CW'(geo.rw);
    rh  = CW'(geo.rh);
    cx  = CW'(geo.cx);
    cy  = CW'(geo.cy);
    rwl = CW'(geo.rwl);
    rhl = CW'(geo.rhl);

    // A ring one cell wide or tall folds onto itself from both ends.
    if (rw == CW'(1)) begin
      s3_next.cat = (cy < (rh >> 1)) ? cy : rh - CW'(1) - cy;
    end else if (rh == CW'(1)) begin
      s3_next.cat = (cx < (rw >> 1)) ? cx : rw - CW'(1) - cx;
    end else if (cy == CW'(0)) begin
      s3_next.cat = cx;
    end else if (cy == rh - CW'(1)) begin
      s3_next.cat = rw - CW'(1) - cx;
    end else if (cx == CW'(0)) begin
      s3_next.cat = rw + rh - CW'(2) - cy;
    end else if (cx == rw - CW'(1)) begin
      s3_next.cat = rw + cy - CW'(1);
    end else begin
      s3_next.cat = CW'(0);
    end

    // Number of categories on the innermost ring.
    if (rwl == CW'(1)) begin
      s3_next.cnt_l = (rhl + CW'(1)) >> 1;
    end else if (rhl == CW'(1)) begin
      s3_next.cnt_l = (rwl + CW'(1)) >> 1;
    end else begin
      s3_next.cnt_l = rwl + rhl - CW'(2);
    end

    // Categories before ring r: r*(w+h-2) - 2*r*r + 2*r.
    s3_next.rb_r = geo.pr_sum - {geo.pr_sq, 1'b0} + KW'({geo.r, 1'b0});
    s3_next.rb_l = geo.pl_sum - {geo.pl_sq, 1'b0} + KW'({geo.last, 1'b0});
    s3_next.outside  = geo.outside;
    s3_next.progress = geo.progress;
  end

  // Stage four: absolute category and total count.
  always_comb begin
    cnt_next.outside  = s3.outside;
    cnt_next.k        = s3.rb_r + KW'(s3.cat);
    cnt_next.total    = s3.rb_l + KW'(s3.cnt_l);
    cnt_next.progress = s3.progress;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v3        <= in_valid;
      out_valid <= v3;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ce) begin
      s3  <= s3_next;
      cnt <= cnt_next;
    end
  end

endmodule

// File: src/srfl_shade.sv
// Fade weight, clamp and grey level output register (stages five to seven).
module srfl_shade (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ce,
  input  logic                                in_valid,
  input  srfl_pkg::cnt_t                      cnt,
  output logic                                out_valid,
  output logic [srfl_pkg::LEVEL_BITS-1:0]     level,
  output logic                                outside
);

  localparam int F  = srfl_pkg::FRACTION_BITS;
  localparam int KW = srfl_pkg::CNT_BITS;
  localparam int AW = KW + F;
  localparam int PW = srfl_pkg::PROG_BITS + KW;
  localparam int DW = (AW > PW) ? AW : PW;
  localparam int LW = F + 1 + srfl_pkg::LEVEL_BITS;

  logic          v5;
  logic          v6;
  logic          o5;
  logic          o6;
  logic [AW-1:0] a5;
  logic [PW-1:0] p5;
  logic [F:0]    t6;
  logic [F:0]    t6_next;
  logic [DW-1:0] diff;
  logic [LW-1:0] scaled;

  // Stage six: t = (k+1)*2^F - progress*N, clamped to [0, 2^F].
  always_comb begin
    diff = DW'(a5) - DW'(p5);
    if (DW'(a5) < DW'(p5)) begin
      t6_next = '0;
    end else if (diff > DW'(1 << F)) begin
      t6_next = (F+1)'(1 << F);
    end else begin
      t6_next = diff[F:0];
    end
  end

  // Stage seven: scale to the grey range and truncate.
  assign scaled = LW'(t6) * LW'(srfl_pkg::LEVEL_MAX);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v5        <= in_valid;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  // Payload registers; stage five holds the two terms of the weight.
  always_ff @(posedge clk) begin
    if (ce) begin
      o5      <= cnt.outside;
      a5      <= {(cnt.k + KW'(1)), {F{1'b0}}};
      p5      <= PW'(cnt.progress) * PW'(cnt.total);
      o6      <= o5;
      t6      <= t6_next;
      outside <= o6;
      level   <= o6 ? '0 : scaled[F +: srfl_pkg::LEVEL_BITS];
    end
  end

endmodule

// File: src/spiral_ring_fade_level.sv
// Top level of the spiral ring fade level generator: registers, handshake, pipeline.
//
//  Channel   Direction  Carries
//  s_axis    in         cell_x [11:0], cell_y [23:12] in tdata
//  m_axis    out        level [7:0] in tdata, outside in tuser
//  cfg       in         grid_width (0), grid_height (1), progress (2)
//
// One cell enters per cycle unless m_axis stalls; each result leaves from the last register stage.
// The seven register stages are set by the ring products, the category logic and
// the progress by count multiplier, each with a stage of its own.
// Reset clears all valid bits and loads an 8 by 5 grid with progress zero.
// A stall on m_axis holds every stage, so s_axis_tready falls with it.
module spiral_ring_fade_level (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [srfl_pkg::S_DATA_BITS-1:0]      s_axis_tdata,  // cell_x, cell_y
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [srfl_pkg::M_DATA_BITS-1:0]      m_axis_tdata,  // level
  output logic [0:0]                            m_axis_tuser,  // outside
  input  logic                                  cfg_we,
  input  logic [srfl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [srfl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CB = srfl_pkg::COORD_BITS;

  logic                              ce;
  logic [CB-1:0]                     grid_width;
  logic [CB-1:0]                     grid_height;
  logic [srfl_pkg::PROG_BITS-1:0]    progress;
  logic                              v_geo;
  logic                              v_cnt;
  srfl_pkg::geo_t                    geo;
  srfl_pkg::cnt_t                    cnt;
  logic [srfl_pkg::LEVEL_BITS-1:0]   level;
  logic                              outside;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CB'(8);
      grid_height <= CB'(5);
      progress    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        srfl_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[CB-1:0];
        srfl_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[CB-1:0];
        srfl_pkg::CFG_PROGRESS:    progress    <= cfg_data[srfl_pkg::PROG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  srfl_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_axis_tvalid),
    .x        (s_axis_tdata[CB-1:0]),
    .y        (s_axis_tdata[2*CB-1:CB]),
    .w        (grid_width),
    .h        (grid_height),
    .progress (progress),
    .out_valid(v_geo),
    .geo      (geo)
  );

  srfl_count u_count (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v_geo),
    .geo      (geo),
    .out_valid(v_cnt),
    .cnt      (cnt)
  );

  srfl_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v_cnt),
    .cnt      (cnt),
    .out_valid(m_axis_tvalid),
    .level    (level),
    .outside  (outside)
  );

  assign m_axis_tdata = srfl_pkg::M_DATA_BITS'(level);
  assign m_axis_tuser = outside;

  `include "spiral_ring_fade_level_assert.svh"

  // A cell outside the grid always comes out fully faded.
  `SRFL_ASSERT_NOW(a_outside_zero, m_axis_tvalid && outside, level == '0, "outside cell lit")
  // A stall freezes the valid bits of every stage.
  `SRFL_ASSERT_NEXT(a_stall_hold, !ce, $stable({v_geo, v_cnt, m_axis_tvalid}), "moved in a stall")

endmodule
